// ===== sv/xml_entity_unescape_core_macros.svh =====
// Assertion macros shared by the entity decoder modules.
`ifndef XML_ENTITY_UNESCAPE_CORE_MACROS_SVH
`define XML_ENTITY_UNESCAPE_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define XEU_ASSERT_NOW(label, ant, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("entity decoder check failed");

`define XEU_ASSERT_NEXT(label, ant, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("entity decoder check failed");

`else

`define XEU_ASSERT_NOW(label, ant, cons)

`define XEU_ASSERT_NEXT(label, ant, cons)

`endif

`endif

// ===== sv/xeu_pkg.sv =====
// Types, entity pattern tables and helpers for the entity decoder.
package xeu_pkg;

    typedef logic [7:0] t_byte;

    localparam int    PatCount = 5;
    localparam t_byte AmpMark  = 8'h26;

    // Pattern order: lt, gt, amp, apos, quot; padded to eight positions.
    localparam t_byte PAT_TEXT [PatCount][8] = '{
        '{8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h67, 8'h74, 8'h3b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b, 8'h00, 8'h00, 8'h00},
        '{8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] PAT_LEN [PatCount] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5};
    localparam t_byte PAT_CHAR [PatCount] = '{8'h3c, 8'h3e, 8'h26, 8'h27, 8'h22};

    typedef struct packed {
        logic  valid;
        t_byte out_char;
        logic  status;
        logic  end_of_string;
    } t_result;

    function automatic t_byte fold_case(input t_byte c);
        t_byte r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

// ===== sv/xeu_decode.sv =====
// Entity match state and per-character decode step.
`include "xml_entity_unescape_core_macros.svh"

module xeu_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  xeu_pkg::t_byte   i_char,
    input  logic             i_end,
    output xeu_pkg::t_result o_result
);

    logic       r_in_entity;
    logic [4:0] r_alive;
    logic [2:0] r_pos;
    logic       r_rejected;

    logic       n_in_entity;
    logic [4:0] n_alive;
    logic [2:0] n_pos;
    logic       n_rejected;

    xeu_pkg::t_byte lc;
    xeu_pkg::t_byte ch;
    logic [4:0]     hit;
    logic           have;
    logic           bad;

    always_comb begin
        lc   = xeu_pkg::fold_case(i_char);
        hit  = '0;
        have = 1'b0;
        ch   = '0;
        for (int i = 0; i < xeu_pkg::PatCount; i++) begin
            hit[i] = r_alive[i] && (r_pos < xeu_pkg::PAT_LEN[i]) &&
                     (xeu_pkg::PAT_TEXT[i][r_pos] == lc);
        end

        n_in_entity = r_in_entity;
        n_alive     = r_alive;
        n_pos       = r_pos;
        n_rejected  = r_rejected;

        if (!r_rejected) begin
            if (r_in_entity) begin
                for (int i = 0; i < xeu_pkg::PatCount; i++) begin
                    if (hit[i] && ({1'b0, r_pos} + 4'd1 == {1'b0, xeu_pkg::PAT_LEN[i]})) begin
                        have = 1'b1;
                        ch   = xeu_pkg::PAT_CHAR[i];
                    end
                end
                if (have) begin
                    n_in_entity = 1'b0;
                    n_alive     = '0;
                    n_pos       = '0;
                end else if (hit == '0) begin
                    n_rejected  = 1'b1;
                    n_in_entity = 1'b0;
                    n_alive     = '0;
                    n_pos       = '0;
                end else begin
                    n_alive = hit;
                    n_pos   = r_pos + 3'd1;
                end
            end else if (i_char == xeu_pkg::AmpMark) begin
                n_in_entity = 1'b1;
                n_alive     = '1;
                n_pos       = '0;
            end else begin
                have = 1'b1;
                ch   = i_char;
            end
        end

        bad = n_rejected || n_in_entity;

        o_result.valid         = have || i_end;
        o_result.out_char      = (i_end && bad) ? 8'h00 : ch;
        o_result.status        = i_end && bad;
        o_result.end_of_string = i_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_entity <= 1'b0;
            r_alive     <= '0;
            r_pos       <= '0;
            r_rejected  <= 1'b0;
        end else if (i_step) begin
            // return to the clean state at the end of every string
            if (i_end) begin
                r_in_entity <= 1'b0;
                r_alive     <= '0;
                r_pos       <= '0;
                r_rejected  <= 1'b0;
            end else begin
                r_in_entity <= n_in_entity;
                r_alive     <= n_alive;
                r_pos       <= n_pos;
                r_rejected  <= n_rejected;
            end
        end
    end

    `XEU_ASSERT_NOW(a_reject_leaves_entity, r_rejected, !r_in_entity)
    `XEU_ASSERT_NOW(a_entity_has_live_pattern, r_in_entity, r_alive != 5'd0)
    `XEU_ASSERT_NOW(a_idle_match_clear, !r_in_entity, r_alive == 5'd0 && r_pos == 3'd0)

endmodule

// ===== sv/xml_entity_unescape_core.sv =====
// Top level: streaming decoder for the five predefined XML entities.
// An accepted character is held in the input register; its result is then registered in the output register.
// Throughput: one character per cycle; with both registers full the output stall reaches o_stall.
// Each character gives zero or one result; the last character of a string always gives one.
// Reset (synchronous, active low) clears the valid flags and the entity match state.
`include "xml_entity_unescape_core_macros.svh"

module xml_entity_unescape_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_char,
    input  logic       i_is_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_status,
    output logic       o_end_of_string
);

    logic           r_in_valid;
    xeu_pkg::t_byte r_in_char;
    logic           r_in_end;

    logic           r_out_valid;
    xeu_pkg::t_byte r_out_char;
    logic           r_out_status;
    logic           r_out_end;

    logic             out_free;
    logic             step;
    xeu_pkg::t_result res;

    assign out_free = !r_out_valid || !i_stall;
    assign step     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    xeu_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_char   (r_in_char),
        .i_end    (r_in_end),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_char <= i_in_char;
            r_in_end  <= i_is_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && res.valid;
        end
    end

    // hold the payload while a result waits for its transfer
    always_ff @(posedge i_clk) begin
        if (step && res.valid) begin
            r_out_char   <= res.out_char;
            r_out_status <= res.status;
            r_out_end    <= res.end_of_string;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_char      = r_out_char;
    assign o_status        = r_out_status;
    assign o_end_of_string = r_out_end;

    `XEU_ASSERT_NOW(a_reject_has_no_char, o_valid && o_status, o_out_char == 8'h00)
    `XEU_ASSERT_NOW(a_reject_only_at_end, o_valid && o_status, o_end_of_string)
    `XEU_ASSERT_NEXT(a_end_gives_result, step && r_in_end, r_out_valid && r_out_end)

endmodule

// ===== tb/xml_entity_unescape_core_tb.sv =====
// Self-checking testbench for the streaming XML entity decoder core.
module xml_entity_unescape_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] AMPERSAND  = 8'h26;
    localparam int         ENT_COUNT  = 5;
    localparam int         IDLE_LIMIT = 2000;
    localparam int         CHAR_GOAL  = 2000;

    typedef enum int {ENT_LT, ENT_GT, ENT_AMP, ENT_APOS, ENT_QUOT} t_entity;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       drain;
    } t_text_char;

    typedef struct packed {
        logic [7:0] out_char;
        logic       status;
        logic       eos;
    } t_decoded;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_in_char = 8'h00;
    logic       i_is_end  = 1'b0;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_char;
    logic       o_status;
    logic       o_end_of_string;

    t_text_char  text_q [$];
    t_decoded    decoded_q [$];
    t_text_char  next_char;
    t_decoded    want;
    t_stall_mode stall_mode = STALL_NONE;

    // Decoder state mirrored by the testbench
    logic       dec_in_entity = 1'b0;
    logic [4:0] dec_alive     = 5'd0;
    logic [2:0] dec_pos       = 3'd0;
    logic       dec_rejected  = 1'b0;

    logic in_fire     = 1'b0;
    int   fail_count  = 0;
    int   taken_count = 0;
    int   char_total  = 0;
    int   idle_cycles = 0;
    int   burst_left  = 1;
    int   gap_left    = 0;
    int   stall_tick  = 0;

    xml_entity_unescape_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_in_char       (i_in_char),
        .i_is_end        (i_is_end),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_char      (o_out_char),
        .o_status        (o_status),
        .o_end_of_string (o_end_of_string)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic string entity_name(input t_entity e);
        case (e)
            ENT_LT:   return "lt;";
            ENT_GT:   return "gt;";
            ENT_AMP:  return "amp;";
            ENT_APOS: return "apos;";
            default:  return "quot;";
        endcase
    endfunction

    function automatic logic [7:0] entity_char(input t_entity e);
        case (e)
            ENT_LT:   return 8'h3c;
            ENT_GT:   return 8'h3e;
            ENT_AMP:  return 8'h26;
            ENT_APOS: return 8'h27;
            default:  return 8'h22;
        endcase
    endfunction

    function automatic logic [7:0] mixed_case(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 1) == 1) begin
            return c - 8'd32;
        end
        return c;
    endfunction

    // Advance the mirrored decoder by one character and queue what it yields.
    function automatic void decode_char(input logic [7:0] c, input logic last);
        logic [7:0] lc;
        logic [7:0] hit_char;
        logic [4:0] still;
        logic       hit;
        logic       bad;
        string      nm;
        hit      = 1'b0;
        hit_char = 8'h00;
        still    = 5'd0;
        if (!dec_rejected) begin
            if (dec_in_entity) begin
                lc = c;
                if (c >= 8'h41 && c <= 8'h5a) begin
                    lc = c + 8'd32;
                end
                for (int k = 0; k < ENT_COUNT; k++) begin
                    nm = entity_name(t_entity'(k));
                    if (dec_alive[k] && dec_pos < nm.len() && nm[dec_pos] == lc) begin
                        still[k] = 1'b1;
                        if (dec_pos + 1 == nm.len()) begin
                            hit      = 1'b1;
                            hit_char = entity_char(t_entity'(k));
                        end
                    end
                end
                if (hit || still == 5'd0) begin
                    dec_rejected  = !hit;
                    dec_in_entity = 1'b0;
                    dec_alive     = 5'd0;
                    dec_pos       = 3'd0;
                end else begin
                    dec_alive = still;
                    dec_pos   = dec_pos + 3'd1;
                end
            end else if (c == AMPERSAND) begin
                dec_in_entity = 1'b1;
                dec_alive     = 5'h1f;
                dec_pos       = 3'd0;
            end else begin
                hit      = 1'b1;
                hit_char = c;
            end
        end
        if (last) begin
            bad           = dec_rejected || dec_in_entity;
            dec_in_entity = 1'b0;
            dec_alive     = 5'd0;
            dec_pos       = 3'd0;
            dec_rejected  = 1'b0;
            decoded_q.push_back('{out_char: bad ? 8'h00 : hit_char, status: bad, eos: 1'b1});
        end else if (hit) begin
            decoded_q.push_back('{out_char: hit_char, status: 1'b0, eos: 1'b0});
        end
    endfunction

    task automatic add_char(input logic [7:0] c, input logic last, input logic drain);
        text_q.push_back('{ch: c, last: last, drain: drain});
    endtask

    task automatic add_text(input string s);
        for (int j = 0; j < s.len(); j++) begin
            add_char(s[j], j == s.len() - 1, 1'b0);
        end
    endtask

    // Random characters and entities in random case; most entities whole, some truncated or corrupted.
    task automatic add_random_string(input logic drain);
        logic [7:0] chars [$];
        logic [7:0] c;
        string      nm;
        int         n_tok;
        int         r;
        int         cut;
        int         pick;
        n_tok = $urandom_range(1, 6);
        for (int t = 0; t < n_tok; t++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                c = 8'($urandom_range(1, 255));
                if (c == AMPERSAND) begin
                    c = c + 8'd1;
                end
                chars.push_back(c);
            end else begin
                nm   = entity_name(t_entity'($urandom_range(0, ENT_COUNT - 1)));
                cut  = nm.len();
                pick = -1;
                if (r >= 80 && r < 92) begin
                    cut = $urandom_range(0, nm.len() - 1);
                end else if (r >= 92) begin
                    pick = $urandom_range(0, nm.len() - 1);
                end
                chars.push_back(AMPERSAND);
                for (int j = 0; j < cut; j++) begin
                    c = (j == pick) ? 8'($urandom_range(1, 255)) : mixed_case(nm[j]);
                    chars.push_back(c);
                end
            end
        end
        for (int j = 0; j < chars.size(); j++) begin
            add_char(chars[j], j == chars.size() - 1, drain && j == 0);
        end
    endtask

    // Sender: bursts and gaps; receiver: a stall pattern whose mode is redrawn at random from the four stall modes
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 256 == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
        end
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default:     i_stall <= (stall_tick % 16 < 6);
        endcase

        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_fire) begin
            // hold the stalled transfer
        end else if (text_q.size() != 0 && gap_left == 0 &&
                     !(text_q[0].drain && decoded_q.size() != 0)) begin
            next_char = text_q.pop_front();
            i_valid   <= 1'b1;
            i_in_char <= next_char.ch;
            i_is_end  <= next_char.last;
            if (burst_left <= 1) begin
                if ($urandom_range(0, 7) == 0) begin
                    burst_left <= $urandom_range(50, 200);
                    gap_left   <= 0;
                end else begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= $urandom_range(0, 4);
                end
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            i_valid <= 1'b0;
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
            end
        end
    end

    // Check results first: a transfer taken at this edge cannot show at the output yet
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result: out_char %02h status %0b end_of_string %0b",
                           o_out_char, o_status, o_end_of_string);
                    fail_count = fail_count + 1;
                end else begin
                    want = decoded_q.pop_front();
                    if (o_out_char !== want.out_char) begin
                        $error("out_char: expected %02h, got %02h", want.out_char, o_out_char);
                        fail_count = fail_count + 1;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0b, got %0b", want.status, o_status);
                        fail_count = fail_count + 1;
                    end
                    if (o_end_of_string !== want.eos) begin
                        $error("end_of_string: expected %0b, got %0b",
                               want.eos, o_end_of_string);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                decode_char(i_in_char, i_is_end);
                taken_count = taken_count + 1;
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        // directed strings: field extremes, every entity, early end and unknown entity
        add_char(8'h01, 1'b0, 1'b0);
        add_char(8'hff, 1'b1, 1'b0);
        add_text("&lt;&GT;&amp;&Apos;&qUOt;");
        add_text("&");
        add_text("&z9");
        add_random_string(1'b1);
        while (text_q.size() < CHAR_GOAL) begin
            add_random_string($urandom_range(0, 39) == 0);
        end
        char_total = text_q.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (taken_count == char_total);
        while (decoded_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && decoded_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
